FILE: rtl/core/sist_pkg.sv
// Package for the sorted interval set table: operation and error codes,
// default sizes and the per-entry push flags shared by the merge and top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sist_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FUNC_W          = 3;
  localparam int ERR_W           = 2;
  localparam int COUNT_OUT_W     = 5;

  localparam logic [FUNC_W-1:0] FUNC_ADD       = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLOOR     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CEILING   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_INTERSECT = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_QUERY     = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED    = 3'd7;

  localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_INVERTED = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL     = 2'd2;

  typedef struct packed {
    logic push_a;
    logic push_b;
    logic placed;
    logic hit;
  } sist_push_t;

endpackage
`default_nettype wire

FILE: rtl/core/sorted_interval_set_table_unit.sv
// Sorted interval set table: one operation per request, one result per request.
// Clear, rejected and no-op requests go straight to the result; otherwise each stored entry
// is read and evaluated in turn, with an extra write per split or placed entry, and when
// the count is unchanged the entries are read and compared again for the change check;
// the pace is set by the single read port of the entry memories.
// One request at a time; the next is taken once the result sits in the output register.
// Reset empties the table at once; memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sorted_interval_set_table_unit #(
  parameter int TABLE_DEPTH = sist_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = sist_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // low_bound, high_bound, probe_value (from bit 0 up), zero padded
  input  wire logic [((3*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // func
  input  wire logic [sist_pkg::FUNC_W-1:0] s_axis_tuser,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // is_member, table_changed, error_code, entry_count, smallest_low, largest_high
  // (from bit 0 up), zero padded
  output logic [((9+2*VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int VW    = VALUE_WIDTH;
  localparam int IW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH+1);
  localparam int OUT_W = ((9+2*VW+7)/8)*8;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_EVAL = 4'd2;
  localparam logic [3:0] ST_WB   = 4'd3;
  localparam logic [3:0] ST_TAIL = 4'd4;
  localparam logic [3:0] ST_CHK  = 4'd5;
  localparam logic [3:0] ST_CRD  = 4'd6;
  localparam logic [3:0] ST_CCMP = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] loop_exit;

  logic [sist_pkg::FUNC_W-1:0] func_r;
  logic signed [VW-1:0] lo_r, hi_r, probe_r, mlo, mhi, b_lo_r, b_hi_r;
  logic signed [VW-1:0] first_low, last_high, new_first, new_last;
  logic placed, member, changed, ovf, sel;
  logic [sist_pkg::ERR_W-1:0] err;
  logic [CW-1:0] count, idx, wptr, idx_inc;

  logic [2*VW-1:0] rd0, rd1, rd_cur, rd_new, wdata;
  logic we0, we1, push;
  logic signed [VW-1:0] push_lo, push_hi;
  logic signed [VW-1:0] cur_lo, cur_hi;

  sist_pkg::sist_push_t flags;
  logic signed [VW-1:0] a_lo, a_hi, b_lo, b_hi, mlo_next, mhi_next;

  logic accept;
  logic [VW-1:0] in_lo, in_hi, in_probe;
  logic out_load;

  assign in_lo    = s_axis_tdata[VW-1:0];
  assign in_hi    = s_axis_tdata[2*VW-1:VW];
  assign in_probe = s_axis_tdata[3*VW-1:2*VW];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // bank sel holds the current table; new entries go to the other bank
  assign rd_cur = sel ? rd1 : rd0;
  assign rd_new = sel ? rd0 : rd1;
  assign cur_lo = rd_cur[VW-1:0];
  assign cur_hi = rd_cur[2*VW-1:VW];

  sist_ram #(.WIDTH(2*VW), .DEPTH(TABLE_DEPTH)) u_bank0 (
    .clk(clk), .we(we0), .waddr(wptr[IW-1:0]), .wdata(wdata),
    .raddr(idx[IW-1:0]), .rdata(rd0)
  );

  sist_ram #(.WIDTH(2*VW), .DEPTH(TABLE_DEPTH)) u_bank1 (
    .clk(clk), .we(we1), .waddr(wptr[IW-1:0]), .wdata(wdata),
    .raddr(idx[IW-1:0]), .rdata(rd1)
  );

  sist_merge #(.VALUE_WIDTH(VW)) u_merge (
    .func(func_r), .lo(lo_r), .hi(hi_r), .probe(probe_r),
    .x(cur_lo), .y(cur_hi), .mlo(mlo), .mhi(mhi), .placed(placed),
    .flags(flags), .a_lo(a_lo), .a_hi(a_hi), .b_lo(b_lo), .b_hi(b_hi),
    .mlo_next(mlo_next), .mhi_next(mhi_next)
  );

  assign idx_inc = idx + CW'(1);

  always_comb begin
    push    = 1'b0;
    push_lo = a_lo;
    push_hi = a_hi;
    case (state)
      ST_EVAL: begin
        push = flags.push_a;
      end
      ST_WB: begin
        push    = 1'b1;
        push_lo = b_lo_r;
        push_hi = b_hi_r;
      end
      ST_TAIL: begin
        push    = 1'b1;
        push_lo = mlo;
        push_hi = mhi;
      end
      default: begin
      end
    endcase
  end

  // drop pushes past the last entry and flag the overflow instead
  assign wdata = {push_hi, push_lo};
  assign we0   = push && (wptr != CW'(TABLE_DEPTH)) && sel;
  assign we1   = push && (wptr != CW'(TABLE_DEPTH)) && !sel;

  always_comb begin
    if (func_r == sist_pkg::FUNC_QUERY) begin
      loop_exit = ST_DONE;
    end else if (func_r == sist_pkg::FUNC_ADD && !(state == ST_EVAL ? flags.placed : placed)) begin
      loop_exit = ST_TAIL;
    end else begin
      loop_exit = ST_CHK;
    end
  end

  assign out_load = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if ((s_axis_tuser == sist_pkg::FUNC_ADD || s_axis_tuser == sist_pkg::FUNC_REMOVE ||
               s_axis_tuser == sist_pkg::FUNC_INTERSECT) && $signed(in_lo) > $signed(in_hi)) begin
            state_next = ST_DONE;
          end else if (s_axis_tuser == sist_pkg::FUNC_CLEAR || s_axis_tuser > sist_pkg::FUNC_CLEAR
                       || (s_axis_tuser == sist_pkg::FUNC_REMOVE && in_lo == in_hi)) begin
            state_next = ST_DONE;
          end else if (count == '0) begin
            if (s_axis_tuser == sist_pkg::FUNC_QUERY) begin
              state_next = ST_DONE;
            end else if (s_axis_tuser == sist_pkg::FUNC_ADD) begin
              state_next = ST_TAIL;
            end else begin
              state_next = ST_CHK;
            end
          end else begin
            state_next = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (flags.push_b) begin
          state_next = ST_WB;
        end else if (idx_inc == count) begin
          state_next = loop_exit;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_WB: begin
        state_next = (idx == count) ? loop_exit : ST_RD;
      end
      ST_TAIL: begin
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (ovf || wptr != count || count == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_CRD;
        end
      end
      ST_CRD: begin
        state_next = ST_CCMP;
      end
      ST_CCMP: begin
        if (rd_cur != rd_new || idx_inc == count) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_CRD;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      sel           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept && s_axis_tuser == sist_pkg::FUNC_CLEAR) begin
            count <= '0;
          end
        end
        ST_CHK: begin
          if (!ovf && wptr != count) begin
            sel   <= !sel;
            count <= wptr;
          end
        end
        ST_CCMP: begin
          if (rd_cur != rd_new) begin
            sel <= !sel;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // request registers and the evaluation datapath; no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= s_axis_tuser;
      lo_r    <= in_lo;
      hi_r    <= in_hi;
      probe_r <= in_probe;
      mlo     <= in_lo;
      mhi     <= in_hi;
      placed  <= 1'b0;
      member  <= 1'b0;
      ovf     <= 1'b0;
      wptr    <= '0;
      idx     <= '0;
      changed <= (s_axis_tuser == sist_pkg::FUNC_CLEAR) && (count != '0);
      if ((s_axis_tuser == sist_pkg::FUNC_ADD || s_axis_tuser == sist_pkg::FUNC_REMOVE ||
           s_axis_tuser == sist_pkg::FUNC_INTERSECT) && $signed(in_lo) > $signed(in_hi)) begin
        err <= sist_pkg::ERR_INVERTED;
      end else begin
        err <= sist_pkg::ERR_OK;
      end
    end
    if (push) begin
      if (wptr == CW'(TABLE_DEPTH)) begin
        ovf <= 1'b1;
      end else begin
        wptr <= wptr + CW'(1);
        if (wptr == '0) begin
          new_first <= push_lo;
        end
        new_last <= push_hi;
      end
    end
    case (state)
      ST_EVAL: begin
        idx    <= idx_inc;
        placed <= flags.placed;
        mlo    <= mlo_next;
        mhi    <= mhi_next;
        b_lo_r <= b_lo;
        b_hi_r <= b_hi;
        if (flags.hit) begin
          member <= 1'b1;
        end
      end
      ST_CHK: begin
        idx <= '0;
        if (ovf) begin
          err <= sist_pkg::ERR_FULL;
        end else if (wptr != count) begin
          changed   <= 1'b1;
          first_low <= new_first;
          last_high <= new_last;
        end
      end
      ST_CCMP: begin
        idx <= idx_inc;
        if (rd_cur != rd_new) begin
          changed   <= 1'b1;
          first_low <= new_first;
          last_high <= new_last;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      m_axis_tdata <= OUT_W'({(count != '0) ? last_high : VW'(0),
                              (count != '0) ? first_low : VW'(0),
                              sist_pkg::COUNT_OUT_W'(count), err, changed, member});
    end
  end

  // --- checks ---
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH)) else $error("entry count above table depth");

  a_err_no_change: assert property (@(posedge clk) disable iff (rst)
    out_load && err != sist_pkg::ERR_OK |-> !changed)
    else $error("rejected request reported a table change");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    (we0 || we1) |-> state != ST_IDLE && !(we0 && we1))
    else $error("entry write outside an operation");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready) else $error("request taken while busy");

endmodule
`default_nettype wire

FILE: rtl/core/sist_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sist_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/sist_merge.sv
// Per-entry evaluation of one stored interval against the current operation:
// decides which new entries to push and updates the running add merge.
// Depends on sist_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sist_merge #(
  parameter int VALUE_WIDTH = sist_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic [sist_pkg::FUNC_W-1:0]   func,
  input  wire logic signed [VALUE_WIDTH-1:0] lo,
  input  wire logic signed [VALUE_WIDTH-1:0] hi,
  input  wire logic signed [VALUE_WIDTH-1:0] probe,
  input  wire logic signed [VALUE_WIDTH-1:0] x,
  input  wire logic signed [VALUE_WIDTH-1:0] y,
  input  wire logic signed [VALUE_WIDTH-1:0] mlo,
  input  wire logic signed [VALUE_WIDTH-1:0] mhi,
  input  wire logic                          placed,
  output sist_pkg::sist_push_t               flags,
  output logic signed [VALUE_WIDTH-1:0]      a_lo,
  output logic signed [VALUE_WIDTH-1:0]      a_hi,
  output logic signed [VALUE_WIDTH-1:0]      b_lo,
  output logic signed [VALUE_WIDTH-1:0]      b_hi,
  output logic signed [VALUE_WIDTH-1:0]      mlo_next,
  output logic signed [VALUE_WIDTH-1:0]      mhi_next
);

  logic signed [VALUE_WIDTH-1:0] cx;
  logic signed [VALUE_WIDTH-1:0] cy;

  always_comb begin
    cx = (func != sist_pkg::FUNC_CEILING && x < lo) ? lo : x;
    cy = (func != sist_pkg::FUNC_FLOOR && y > hi) ? hi : y;
    flags.push_a = 1'b0;
    flags.push_b = 1'b0;
    flags.placed = placed;
    flags.hit    = 1'b0;
    a_lo = x;
    a_hi = y;
    b_lo = x;
    b_hi = y;
    mlo_next = mlo;
    mhi_next = mhi;
    case (func)
      sist_pkg::FUNC_ADD: begin
        if (y < lo) begin
          flags.push_a = 1'b1;
        end else if (x > hi) begin
          if (!placed) begin
            // emit the merged interval ahead of this entry
            flags.push_a = 1'b1;
            flags.push_b = 1'b1;
            flags.placed = 1'b1;
            a_lo = mlo;
            a_hi = mhi;
          end else begin
            flags.push_a = 1'b1;
          end
        end else begin
          mlo_next = (x < mlo) ? x : mlo;
          mhi_next = (y > mhi) ? y : mhi;
        end
      end
      sist_pkg::FUNC_REMOVE: begin
        flags.push_a = (x <= lo);
        a_hi = (y < lo) ? y : lo;
        flags.push_b = (y >= hi);
        b_lo = (x > hi) ? x : hi;
      end
      sist_pkg::FUNC_FLOOR, sist_pkg::FUNC_CEILING, sist_pkg::FUNC_INTERSECT: begin
        flags.push_a = (cx <= cy);
        a_lo = cx;
        a_hi = cy;
      end
      sist_pkg::FUNC_QUERY: begin
        flags.hit = (x <= probe) && (probe <= y);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
